// ===== rtl/lsp_pkg.sv =====
// Shared types, codes and constants for the LIFO stack with peek.
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int DATA_W  = 32;
    localparam int CAP_W   = 9;
    localparam int POS_W   = 9;
    localparam int CNT_W   = 9;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Register index carried in paddr[PADDR_W-1].
    localparam logic CAP_REG_IDX = 1'b0;

    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TOP  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

    localparam logic signed [DATA_W-1:0] ERR_WORD = -32'sd1;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] push_value;
        logic [POS_W-1:0]         position;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
        logic                     is_full;
    } out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_RESP
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_ram;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic needs_read;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lifo_stack_with_peek.sv =====
// Top level of the LIFO stack with peek: handshake ports, register port and assertions.
`timescale 1ns / 1ps
`default_nettype none

// A last-in first-out stack of signed 32-bit words held in a DEPTH-entry RAM.
// Each input item carries one action: push a word, pop the top, peek at a
// position counted from the top (1 is the top), or read the top in place.
// Every item gives exactly one result item with the word read (zero for a
// good push, -1 on any error), a status code, the entry count after the
// action, and the empty and full flags. A failing action changes nothing.
// Items are handled one at a time: an accepted item is registered, executed,
// and its result is registered and held valid until m_ready; a pop, peek or
// read-top adds a load step, since the entry comes out of the RAM through its
// registered read port. The next item is taken in the cycle after the result
// item is delivered, so no new item is accepted before the last one is done.
// The usable depth is the capacity_limit register at byte address 0, clamped
// to 1..DEPTH (zero acts as one); lowering it below the current count keeps
// the stored entries, and pushes report overflow until pops bring the count
// below the limit. Write the register only while no item is in flight. The
// RAM needs no clearing pass, since only entries below the count are read.

module lifo_stack_with_peek #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire lsp_pkg::in_t                s_item,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output lsp_pkg::out_t                    m_item,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lsp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lsp_pkg::APB_W-1:0]   pwdata,
    output logic      [lsp_pkg::APB_W-1:0]   prdata,
    output logic                             pready
);

    lsp_pkg::cmd_t             cmd;
    lsp_pkg::dp_stat_t         dp_stat;
    logic                      cfg_we;
    logic                      cap_sel;
    logic [lsp_pkg::CAP_W-1:0] cap_value;

    // The register port never stalls. The upper address bit selects the
    // register; writes to addresses past the register list are dropped.
    assign pready  = 1'b1;
    assign cap_sel = (paddr[lsp_pkg::PADDR_W-1] == lsp_pkg::CAP_REG_IDX);
    assign cfg_we  = psel && penable && pwrite && cap_sel;
    assign prdata  = cap_sel ? lsp_pkg::APB_W'(cap_value) : '0;

    lsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_stat (dp_stat),
        .cmd     (cmd)
    );

    lsp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[lsp_pkg::CAP_W-1:0]),
        .dp_stat   (dp_stat),
        .m_item    (m_item),
        .cap_value (cap_value)
    );

`ifndef ASSERT_OFF
    // Only one item is in flight, so input and result sides never open together.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result item is pending");

    // After an accept the block is busy and no result can appear at once.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("controller did not go busy after accepting an item");

    // An overflow only happens at or above the limit, which leaves the stack full.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == lsp_pkg::STAT_OVERFLOW) |-> m_item.is_full)
        else $error("overflow reported on a stack that is not full");

    // The empty flag and a zero count always agree.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.is_empty == (m_item.entry_count == '0)))
        else $error("empty flag disagrees with the entry count");
`endif

endmodule

`default_nettype wire

// ===== rtl/lsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lsp_ctrl.sv =====
// Controller state machine that sequences one stack action at a time.
`timescale 1ns / 1ps
`default_nettype none

module lsp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire lsp_pkg::dp_stat_t dp_stat,
    output lsp_pkg::cmd_t          cmd
);

    lsp_pkg::state_t state_reg;
    lsp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsp_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = lsp_pkg::S_EXEC;
                end
            end
            lsp_pkg::S_EXEC: begin
                state_next = dp_stat.needs_read ? lsp_pkg::S_LOAD : lsp_pkg::S_RESP;
            end
            lsp_pkg::S_LOAD: begin
                state_next = lsp_pkg::S_RESP;
            end
            lsp_pkg::S_RESP: begin
                if (m_ready) begin
                    state_next = lsp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lsp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_ram  = 1'b0;
        case (state_reg)
            lsp_pkg::S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            lsp_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
            end
            lsp_pkg::S_LOAD: begin
                cmd.load_ram = 1'b1;
            end
            lsp_pkg::S_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lsp_dp.sv =====
// Datapath: item register, fill count, limit register, entry RAM and result register.
`timescale 1ns / 1ps
`default_nettype none

module lsp_dp #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lsp_pkg::cmd_t             cmd,
    input  wire lsp_pkg::in_t              s_item,
    input  wire logic                      cfg_we,
    input  wire logic [lsp_pkg::CAP_W-1:0] cfg_wdata,
    output lsp_pkg::dp_stat_t              dp_stat,
    output lsp_pkg::out_t                  m_item,
    output logic      [lsp_pkg::CAP_W-1:0] cap_value
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int LW = (CW > lsp_pkg::CAP_W) ? CW : lsp_pkg::CAP_W;

    lsp_pkg::in_t              item_reg, item_next;
    lsp_pkg::out_t             res_reg, res_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [lsp_pkg::CAP_W-1:0] cap_reg, cap_next;

    logic [LW-1:0]                  cap_one, lim, count_ext, pos_ext;
    logic [LW-1:0]                  cnt_after, rd_addr;
    logic [lsp_pkg::STAT_W-1:0]     stat;
    logic                           do_write, needs_read;
    logic signed [lsp_pkg::DATA_W-1:0] imm_value;
    logic [lsp_pkg::DATA_W-1:0]     ram_rdata;

    // Effective limit: the register clamped to 1..DEPTH.
    assign cap_one   = (cap_reg == '0) ? LW'(1) : LW'(cap_reg);
    assign lim       = (cap_one > LW'(DEPTH)) ? LW'(DEPTH) : cap_one;
    assign count_ext = LW'(count_reg);
    assign pos_ext   = LW'(item_reg.position);

    always_comb begin
        stat       = lsp_pkg::STAT_OK;
        cnt_after  = count_ext;
        do_write   = 1'b0;
        needs_read = 1'b0;
        rd_addr    = count_ext - LW'(1);
        case (item_reg.action)
            lsp_pkg::ACT_PUSH: begin
                if (count_ext >= lim) begin
                    stat = lsp_pkg::STAT_OVERFLOW;
                end else begin
                    do_write  = 1'b1;
                    cnt_after = count_ext + LW'(1);
                end
            end
            lsp_pkg::ACT_POP: begin
                if (count_ext == '0) begin
                    stat = lsp_pkg::STAT_UNDERFLOW;
                end else begin
                    needs_read = 1'b1;
                    cnt_after  = count_ext - LW'(1);
                end
            end
            lsp_pkg::ACT_PEEK: begin
                if (pos_ext == '0 || pos_ext > count_ext) begin
                    stat = lsp_pkg::STAT_BADPOS;
                end else begin
                    needs_read = 1'b1;
                    rd_addr    = count_ext - pos_ext;
                end
            end
            default: begin
                if (count_ext == '0) begin
                    stat = lsp_pkg::STAT_EMPTY;
                end else begin
                    needs_read = 1'b1;
                end
            end
        endcase
    end

    // A successful push returns zero; every error returns the error word.
    assign imm_value = (stat == lsp_pkg::STAT_OK) ? '0 : lsp_pkg::ERR_WORD;

    assign dp_stat.needs_read = needs_read;

    lsp_ram #(
        .WIDTH (lsp_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.exec && do_write),
        .waddr (count_ext[AW-1:0]),
        .wdata (item_reg.push_value),
        .raddr (rd_addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        item_next  = cmd.load_item ? s_item : item_reg;
        count_next = cmd.exec ? cnt_after[CW-1:0] : count_reg;
        cap_next   = cfg_we ? cfg_wdata : cap_reg;
        res_next   = res_reg;
        if (cmd.exec) begin
            res_next.read_value  = imm_value;
            res_next.status      = stat;
            res_next.entry_count = cnt_after[lsp_pkg::CNT_W-1:0];
            res_next.is_empty    = (cnt_after == '0);
            res_next.is_full     = (cnt_after >= lim);
        end
        if (cmd.load_ram) begin
            res_next.read_value = $signed(ram_rdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= lsp_pkg::CAP_RESET;
        end else begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_item    = res_reg;
    assign cap_value = cap_reg;

endmodule

`default_nettype wire
